// File: rtl/plt_pkg.sv
// Shared types and constants for the positional list table.
// Depends on nothing; every other file in rtl uses it.
`default_nettype none

package plt_pkg;

    localparam int unsigned DEPTH_DEFAULT = 128;

    typedef enum logic [2:0] {
        OP_GET    = 3'd0,
        OP_LOCATE = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_ROTATE = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [7:0]         position;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic signed [31:0] read_value;
        logic [7:0]         found_position;
        logic [7:0]         count;
    } out_item_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/plt_cell.sv
// One cell of the list ring: holds a single entry and shifts or rotates it.
// Depends on plt_pkg for the cell command type.
`default_nettype none

module plt_cell #(
    parameter int unsigned DEPTH = plt_pkg::DEPTH_DEFAULT,
    parameter int unsigned INDEX = 0
) (
    input  wire                          clk,
    input  plt_pkg::cell_cmd_t           cmd,
    input  wire [$clog2(DEPTH)-1:0]      slot,
    input  wire [31:0]                   lower_data,
    input  wire [31:0]                   upper_data,
    output logic [31:0]                  data
);

    localparam int unsigned IW = $clog2(DEPTH);

    logic [IW-1:0] my_index;
    logic [31:0]   data_reg;
    logic [31:0]   data_next;

    assign my_index = IW'(INDEX);
    assign data     = data_reg;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            plt_pkg::CELL_HOLD:
            begin
                data_next = data_reg;
            end
            plt_pkg::CELL_ROTATE:
            begin
                data_next = upper_data;
            end
            plt_pkg::CELL_INSERT:
            begin
                // open a gap at slot, take the new value there
                if (my_index > slot)
                begin
                    data_next = lower_data;
                end
                else if (my_index == slot)
                begin
                    data_next = cmd.value;
                end
            end
            plt_pkg::CELL_DELETE:
            begin
                if (my_index >= slot)
                begin
                    data_next = upper_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// File: rtl/plt_ctrl.sv
// Sequencer of the list table: decodes items, keeps the count, walks the ring
// for get and locate, and holds the result item. Depends on plt_pkg.
`default_nettype none

module plt_ctrl #(
    parameter int unsigned DEPTH = plt_pkg::DEPTH_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cmd_valid,
    output logic                         cmd_stall,
    input  plt_pkg::in_item_t            cmd,
    output logic                         res_valid,
    input  wire                          res_stall,
    output plt_pkg::out_item_t           res,
    output plt_pkg::cell_cmd_t           cell_cmd,
    output logic [$clog2(DEPTH)-1:0]     slot,
    input  wire [31:0]                   head_data
);

    localparam int unsigned IW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned CMPW = ((CW > 8) ? CW : 8) + 1;

    plt_pkg::state_t state_reg, state_next;
    plt_pkg::op_t    op;

    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   step_reg, step_next;
    logic [2:0]      op_reg, op_next;
    logic [IW-1:0]   target_reg, target_next;
    logic [31:0]     val_reg, val_next;
    logic            status_reg, status_next;
    logic [31:0]     rd_reg, rd_next;
    logic [7:0]      found_reg, found_next;
    logic            hit_reg, hit_next;

    logic            accept;
    logic            last_step;
    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] cnt_w;
    logic            pos_ok_rd;
    logic            pos_ok_ins;
    logic [CW-1:0]   step_plus;

    assign op         = plt_pkg::op_t'(cmd.opcode);
    assign accept     = cmd_valid && !cmd_stall;
    assign last_step  = (step_reg == IW'(DEPTH - 1));
    assign pos_w      = CMPW'(cmd.position);
    assign cnt_w      = CMPW'(count_reg);
    assign pos_ok_rd  = (cmd.position != 8'd0) && (pos_w <= cnt_w);
    assign pos_ok_ins = (cmd.position != 8'd0) && (pos_w <= cnt_w + CMPW'(1))
                        && (count_reg != CW'(DEPTH));
    assign step_plus  = CW'(step_reg) + CW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plt_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if ((op == plt_pkg::OP_GET && pos_ok_rd) || op == plt_pkg::OP_LOCATE)
                    begin
                        state_next = plt_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = plt_pkg::ST_DONE;
                    end
                end
            end
            plt_pkg::ST_SCAN:
            begin
                if (last_step)
                begin
                    state_next = plt_pkg::ST_DONE;
                end
            end
            plt_pkg::ST_DONE:
            begin
                if (!res_stall)
                begin
                    state_next = plt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and cell commands
    always_comb
    begin
        cmd_stall      = 1'b1;
        res_valid      = 1'b0;
        cell_cmd.op    = plt_pkg::CELL_HOLD;
        cell_cmd.value = cmd.value;
        slot           = IW'(cmd.position - 8'd1);
        unique case (state_reg)
            plt_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid && op == plt_pkg::OP_INSERT && pos_ok_ins)
                begin
                    cell_cmd.op = plt_pkg::CELL_INSERT;
                end
                else if (cmd_valid && op == plt_pkg::OP_DELETE && pos_ok_rd)
                begin
                    cell_cmd.op = plt_pkg::CELL_DELETE;
                end
            end
            plt_pkg::ST_SCAN:
            begin
                cell_cmd.op = plt_pkg::CELL_ROTATE;
            end
            plt_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    assign res.status         = status_reg;
    assign res.read_value     = rd_reg;
    assign res.found_position = found_reg;
    assign res.count          = 8'(count_reg);

    // datapath next values
    always_comb
    begin
        count_next  = count_reg;
        step_next   = step_reg;
        op_next     = op_reg;
        target_next = target_reg;
        val_next    = val_reg;
        status_next = status_reg;
        rd_next     = rd_reg;
        found_next  = found_reg;
        hit_next    = hit_reg;

        if (accept)
        begin
            op_next     = cmd.opcode;
            target_next = IW'(cmd.position - 8'd1);
            val_next    = cmd.value;
            rd_next     = 32'd0;
            found_next  = 8'd0;
            hit_next    = 1'b0;
            step_next   = '0;
            unique case (op)
                plt_pkg::OP_GET:
                begin
                    status_next = !pos_ok_rd;
                end
                plt_pkg::OP_LOCATE:
                begin
                    status_next = 1'b0;
                end
                plt_pkg::OP_INSERT:
                begin
                    status_next = !pos_ok_ins;
                    if (pos_ok_ins)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                plt_pkg::OP_DELETE:
                begin
                    status_next = !pos_ok_rd;
                    if (pos_ok_rd)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                plt_pkg::OP_CLEAR:
                begin
                    status_next = 1'b0;
                    count_next  = '0;
                end
                default:
                begin
                    status_next = 1'b1;
                end
            endcase
        end
        else if (state_reg == plt_pkg::ST_SCAN)
        begin
            // head cell holds the entry at step; advance the ring back to alignment
            step_next = last_step ? '0 : step_reg + IW'(1);
            if (op_reg == plt_pkg::OP_GET && step_reg == target_reg)
            begin
                rd_next = head_data;
            end
            if (op_reg == plt_pkg::OP_LOCATE && !hit_reg
                && CW'(step_reg) < count_reg && head_data == val_reg)
            begin
                hit_next   = 1'b1;
                found_next = 8'(step_plus);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plt_pkg::ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        target_reg <= target_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        found_reg  <= found_next;
        hit_reg    <= hit_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != plt_pkg::ST_SCAN |-> step_reg == '0)
        else $error("ring left out of alignment");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plt_pkg::ST_SCAN && last_step) |=> state_reg == plt_pkg::ST_DONE)
        else $error("scan did not end after a full turn");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == plt_pkg::OP_INSERT && pos_ok_ins)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the count");

    a_no_shift_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != plt_pkg::ST_IDLE |->
        (cell_cmd.op != plt_pkg::CELL_INSERT && cell_cmd.op != plt_pkg::CELL_DELETE))
        else $error("shift issued while an item is in flight");

endmodule

`default_nettype wire

// File: rtl/positional_list_table_top.sv
// Positional list table: a ring of DEPTH entry cells behind one sequencer.
// Get and locate with a valid request walk the ring through the head cell one
// entry per cycle for a full turn before their result appears; insert, delete,
// clear, refused requests and unknown opcodes give their result in the cycle
// after acceptance, since each cell shifts in parallel. One item is in flight
// at a time: the next one is taken the cycle after the result leaves, so a new
// item is never taken before the last one is through.
// Depends on plt_pkg, plt_cell and plt_ctrl.
`default_nettype none

module positional_list_table_top #(
    parameter int unsigned DEPTH = plt_pkg::DEPTH_DEFAULT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_stall,
    input  plt_pkg::in_item_t   cmd,
    output logic                res_valid,
    input  wire                 res_stall,
    output plt_pkg::out_item_t  res
);

    localparam int unsigned IW = $clog2(DEPTH);

    plt_pkg::cell_cmd_t cell_cmd;
    logic [IW-1:0]      slot;
    logic [31:0]        cell_data [DEPTH];

    plt_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cell_cmd  (cell_cmd),
        .slot      (slot),
        .head_data (cell_data[0])
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        plt_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cell_cmd),
            .slot       (slot),
            .lower_data (cell_data[(i + DEPTH - 1) % DEPTH]),
            .upper_data (cell_data[(i + 1) % DEPTH]),
            .data       (cell_data[i])
        );
    end

endmodule

`default_nettype wire
